FILE: rtl/htrc_pkg.sv
// Package for the hysteresis thermostat relay control.
// Holds register indexes, mode codes and reset values; no dependencies.
package htrc_pkg;

    localparam int TEMP_BITS_DEF = 16;
    localparam int HYST_BITS     = 12;
    localparam int WAIT_BITS     = 16;
    localparam int MODE_BITS     = 2;
    localparam int IDX_BITS      = 3;

    typedef logic [IDX_BITS-1:0]  cfg_idx_t;
    typedef logic [MODE_BITS-1:0] mode_t;

    localparam cfg_idx_t REG_MODE   = 3'd0;
    localparam cfg_idx_t REG_TARGET = 3'd1;
    localparam cfg_idx_t REG_HYST   = 3'd2;
    localparam cfg_idx_t REG_WAIT   = 3'd3;

    localparam mode_t MODE_OFF  = 2'd0;
    localparam mode_t MODE_HEAT = 2'd1;
    localparam mode_t MODE_COOL = 2'd2;

    localparam int TARGET_RESET = 320;
    localparam logic [HYST_BITS-1:0] HYST_RESET = 12'd16;
    localparam logic [WAIT_BITS-1:0] WAIT_RESET = 16'd10;
    localparam logic [WAIT_BITS-1:0] COUNT_MAX  = 16'hFFFF;

endpackage

FILE: rtl/hysteresis_thermostat_relay_control.sv
// Top level of the hysteresis thermostat relay control.
// Depends on htrc_pkg for codes, widths and reset values.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_ready  | sample_temp
//  result  | out_valid / out_ready| heater_on, cooler_on, pending_count
//  config  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One sample per cycle sustained while out_ready is high; a sample passes the input register, then the result register.
// The relay and counter update is combinational between input and result registers.
// A stalled result holds the input register; input is refused only when both are full.
// rst_n clears relays, counter and valid flags and loads the register reset values.
// Config is always ready; a mode write with a new value clears relays and counter.
module hysteresis_thermostat_relay_control
    import htrc_pkg::*;
#(
    parameter int TEMP_BITS = TEMP_BITS_DEF,
    parameter int CFG_BITS  = (TEMP_BITS > WAIT_BITS) ? TEMP_BITS : WAIT_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [TEMP_BITS-1:0] sample_temp,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        heater_on,
    output logic                        cooler_on,
    output logic [WAIT_BITS-1:0]        pending_count,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  cfg_idx_t                    cfg_index,
    input  logic [CFG_BITS-1:0]         cfg_data
);

    localparam int CW = ((TEMP_BITS > HYST_BITS) ? TEMP_BITS : HYST_BITS) + 2;
    localparam logic [TEMP_BITS-1:0] TARGET_RST = TEMP_BITS'(TARGET_RESET);

    mode_t                 mode_reg;
    logic [TEMP_BITS-1:0]  target_reg;
    logic [HYST_BITS-1:0]  hyst_reg;
    logic [WAIT_BITS-1:0]  wait_reg;

    logic                  heat_relay_reg, heat_relay_next;
    logic                  cool_relay_reg, cool_relay_next;
    logic [WAIT_BITS-1:0]  count_reg, count_next;

    logic                  s1_valid_reg;
    logic [TEMP_BITS-1:0]  sample_reg;

    logic                  out_valid_reg;
    logic                  heater_on_reg, cooler_on_reg;
    logic [WAIT_BITS-1:0]  pending_count_reg;

    logic                  advance;
    logic                  cfg_xfer;
    logic                  mode_clear;

    logic signed [CW-1:0]  samp_w, tgt_w, hyst_w, low_edge, high_edge;
    logic                  below, above;
    logic                  heating, cooling;
    logic                  relay_cur, on_cond, off_cond, qual;
    logic [WAIT_BITS-1:0]  need, count_inc;

    assign advance    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || advance;
    assign cfg_ready  = 1'b1;
    assign cfg_xfer   = cfg_valid && cfg_ready;
    assign mode_clear = cfg_xfer && (cfg_index == REG_MODE) &&
                        (cfg_data[MODE_BITS-1:0] != mode_reg);

    // widen so the band edges never wrap
    assign samp_w    = {{(CW-TEMP_BITS){sample_reg[TEMP_BITS-1]}}, sample_reg};
    assign tgt_w     = {{(CW-TEMP_BITS){target_reg[TEMP_BITS-1]}}, target_reg};
    assign hyst_w    = {{(CW-HYST_BITS){1'b0}}, hyst_reg};
    assign low_edge  = tgt_w - hyst_w;
    assign high_edge = tgt_w + hyst_w;
    assign below     = samp_w < low_edge;
    assign above     = samp_w > high_edge;

    assign heating   = (mode_reg == MODE_HEAT);
    assign cooling   = (mode_reg == MODE_COOL);
    assign relay_cur = heating ? heat_relay_reg : cool_relay_reg;
    assign on_cond   = heating ? below : above;
    assign off_cond  = heating ? above : below;
    assign qual      = relay_cur ? off_cond : on_cond;
    assign need      = (wait_reg == '0) ? WAIT_BITS'(1) : wait_reg;
    assign count_inc = (count_reg != COUNT_MAX) ? count_reg + WAIT_BITS'(1) : count_reg;

    always_comb
    begin
        heat_relay_next = heat_relay_reg;
        cool_relay_next = cool_relay_reg;
        count_next      = '0;
        if (heating || cooling)
        begin
            if (qual)
            begin
                if (count_inc >= need)
                begin
                    // toggle the active relay and restart the count
                    if (heating)
                    begin
                        heat_relay_next = !heat_relay_reg;
                    end
                    else
                    begin
                        cool_relay_next = !cool_relay_reg;
                    end
                end
                else
                begin
                    count_next = count_inc;
                end
            end
        end
        else
        begin
            heat_relay_next = 1'b0;
            cool_relay_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_OFF;
            target_reg <= TARGET_RST;
            hyst_reg   <= HYST_RESET;
            wait_reg   <= WAIT_RESET;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[MODE_BITS-1:0];
                REG_TARGET: target_reg <= cfg_data[TEMP_BITS-1:0];
                REG_HYST:   hyst_reg   <= cfg_data[HYST_BITS-1:0];
                REG_WAIT:   wait_reg   <= cfg_data[WAIT_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_relay_reg <= 1'b0;
            cool_relay_reg <= 1'b0;
            count_reg      <= '0;
        end
        else if (mode_clear)
        begin
            heat_relay_reg <= 1'b0;
            cool_relay_reg <= 1'b0;
            count_reg      <= '0;
        end
        else if (advance)
        begin
            heat_relay_reg <= heat_relay_next;
            cool_relay_reg <= cool_relay_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg <= sample_temp;
        end
        if (advance)
        begin
            heater_on_reg     <= heat_relay_next;
            cooler_on_reg     <= cool_relay_next;
            pending_count_reg <= count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign heater_on     = heater_on_reg;
    assign cooler_on     = cooler_on_reg;
    assign pending_count = pending_count_reg;

endmodule

FILE: rtl/htrc_checker.sv
// Port-level checker for the hysteresis thermostat relay control.
// Depends on htrc_pkg; bound to the top level at the end of this file.
module htrc_checker
    import htrc_pkg::*;
#(
    parameter int TEMP_BITS = TEMP_BITS_DEF,
    parameter int CFG_BITS  = (TEMP_BITS > WAIT_BITS) ? TEMP_BITS : WAIT_BITS
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic signed [TEMP_BITS-1:0] sample_temp,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        heater_on,
    input logic                        cooler_on,
    input logic [WAIT_BITS-1:0]        pending_count,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input cfg_idx_t                    cfg_index,
    input logic [CFG_BITS-1:0]         cfg_data
);

    // hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(heater_on) &&
        $stable(cooler_on) && $stable(pending_count))
        else $error("stalled result changed");

    // never drive both relays
    a_relay_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(heater_on && cooler_on))
        else $error("heater and cooler both on");

    // accept input whenever the result side is empty
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with empty result register");

    // a transfer with a free result side shows a result after the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
        else $error("result missing after transfer");

    // take configuration at any time
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration refused");

endmodule

bind hysteresis_thermostat_relay_control htrc_checker #(
    .TEMP_BITS (TEMP_BITS),
    .CFG_BITS  (CFG_BITS)
) u_htrc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_temp   (sample_temp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .heater_on     (heater_on),
    .cooler_on     (cooler_on),
    .pending_count (pending_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
);
